@@ src/queue_backlog_escalation_watchdog_assert.svh @@
// Assertion macros for the queue backlog escalation watchdog.
`ifndef QUEUE_BACKLOG_ESCALATION_WATCHDOG_ASSERT_SVH
`define QUEUE_BACKLOG_ESCALATION_WATCHDOG_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define QBEW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define QBEW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define QBEW_ASSERT(lbl, prop, msg)
`define QBEW_NEVER(lbl, cond, msg)
`endif
`endif

@@ src/qbew_pkg.sv @@
// Shared types and constants of the queue backlog escalation watchdog.
package qbew_pkg;

	// Width of one queue size sample.
	localparam int SAMPLE_W = 24;
	// Width of a threshold: five times the level unit times the client factor.
	localparam int STEP_W = 23;
	localparam int THR_W = 26;

	// Queue status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SUSPEND   = 3'd1,
		ST_STOP_NET  = 3'd2,
		ST_SHUTDOWN  = 3'd3,
		ST_TERMINATE = 3'd4
	} status_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_LEVEL_UNIT       = 3'd0;
	localparam logic [2:0] REG_SUSPEND_WINDOW   = 3'd1;
	localparam logic [2:0] REG_RESUME_WINDOW    = 3'd2;
	localparam logic [2:0] REG_STOP_WINDOW      = 3'd3;
	localparam logic [2:0] REG_SHUTDOWN_WINDOW  = 3'd4;
	localparam logic [2:0] REG_TERMINATE_WINDOW = 3'd5;

	// Result of a history walk, handed from the walker to the control.
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [SAMPLE_W-1:0] min_a;
		logic [SAMPLE_W-1:0] min_b;
	} walk_res_t;

endpackage

@@ src/qbew_hist_mem.sv @@
// Sample history ring memory: one write port, one read port, registered read data.
module qbew_hist_mem #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [qbew_pkg::SAMPLE_W-1:0] wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [qbew_pkg::SAMPLE_W-1:0] rdata
);
	import qbew_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/qbew_walker.sv @@
// History walker: reads older samples one per cycle and keeps two running minima.
module qbew_walker #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [AW-1:0]                 cur_addr,
	input  logic [AW-1:0]                 len_a,
	input  logic [AW-1:0]                 len_b,
	input  logic [qbew_pkg::SAMPLE_W-1:0] seed,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [qbew_pkg::SAMPLE_W-1:0] rd_data,
	output qbew_pkg::walk_res_t           res
);
	import qbew_pkg::*;

	logic                busy_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       issue_cnt_q;
	logic [AW-1:0]       len_a_q;
	logic [AW-1:0]       len_b_q;
	logic [AW-1:0]       len_max_q;
	logic                valid_s1;
	logic [AW-1:0]       pos_s1;
	logic [SAMPLE_W-1:0] min_a_q;
	logic [SAMPLE_W-1:0] min_b_q;
	logic [AW-1:0]       prev_addr;
	logic                done;

	// Step back one entry in the ring.
	assign prev_addr = (addr_q == '0) ? AW'(DEPTH - 1) : addr_q - 1'b1;
	assign rd_en     = busy_q && (issue_cnt_q != len_max_q);
	assign rd_addr   = prev_addr;
	assign done      = busy_q && (issue_cnt_q == len_max_q) && !valid_s1;

	// Read issue and tracking of the entry position in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (start) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Walk counters and minima; the current sample seeds both minima.
	always_ff @(posedge clk) begin
		if (start) begin
			addr_q      <= cur_addr;
			issue_cnt_q <= '0;
			len_a_q     <= len_a;
			len_b_q     <= len_b;
			len_max_q   <= (len_a > len_b) ? len_a : len_b;
			min_a_q     <= seed;
			min_b_q     <= seed;
		end else begin
			if (rd_en) begin
				addr_q      <= prev_addr;
				issue_cnt_q <= issue_cnt_q + 1'b1;
				pos_s1      <= issue_cnt_q + 1'b1;
			end
			if (valid_s1) begin
				if ((pos_s1 <= len_a_q) && (rd_data < min_a_q)) begin
					min_a_q <= rd_data;
				end
				if ((pos_s1 <= len_b_q) && (rd_data < min_b_q)) begin
					min_b_q <= rd_data;
				end
			end
		end
	end

	assign res = '{busy: busy_q, done: done, min_a: min_a_q, min_b: min_b_q};

endmodule

@@ src/queue_backlog_escalation_watchdog.sv @@
// Queue backlog escalation watchdog: control, configuration and result register.
//
// Each input beat on the s_ group is one periodic sample of a queue's size and
// of its client count. The sample is stored in a history ring memory, then the
// minimum over the most recent samples of one or two windows is compared with
// thresholds k * level_unit * factor, factor = clamp(1 + clients / 100, 1, 5).
// One output beat on the m_ group follows each input beat: the new status, the
// sync-block flag and the three escalation events.
// Older samples to read are the longer window in use, clamped to the samples
// stored, less the current one. A sample passes in order through acceptance,
// preparation, one history read per older sample (the ring has a single read port),
// the read latency, the close of the walk and the decision, after which
// m_tvalid rises. One sample is processed at a time; s_tready is high while
// idle. A stalled receiver holds m_tvalid and m_tdata in the output register,
// and the next sample is still accepted; its result waits until the register
// is free. Reset clears the status to ok, the flag, the ring pointer and the
// fill count, and loads the register defaults. Configuration writes through
// cfg_we, cfg_addr and cfg_data take effect at once, without read-back.
`include "queue_backlog_escalation_watchdog_assert.svh"
module queue_backlog_escalation_watchdog #(
	parameter int HISTORY_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [19:0] cfg_data,
	// Sample stream. tdata: queue_size [23:0], client_count [39:24].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	// Result stream. tdata: status [2:0], sync_blocked [3], stop_net_event [4],
	// shutdown_event [5], terminate_event [6], zero [7].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata
);
	import qbew_pkg::*;

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int NW = (CW > 8) ? CW : 8;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PREP   = 4'b0010,
		S_WALK   = 4'b0100,
		S_DECIDE = 4'b1000
	} seq_t;

	seq_t                state_q;
	logic [19:0]         level_unit_q;
	logic [7:0]          suspend_win_q;
	logic [7:0]          resume_win_q;
	logic [7:0]          stop_win_q;
	logic [7:0]          shutdown_win_q;
	logic [7:0]          terminate_win_q;
	logic [AW-1:0]       wp_q;
	logic [CW-1:0]       fill_q;
	status_t             status_q;
	logic                block_q;
	logic [SAMPLE_W-1:0] qsize_q;
	logic [2:0]          factor_q;
	logic [AW-1:0]       cur_addr_q;
	logic [STEP_W-1:0]   step_q;
	logic [THR_W-1:0]    thr_lo_q;
	logic [THR_W-1:0]    thr_hi_q;
	logic                out_valid_q;
	logic [7:0]          out_data_q;

	logic                accept;
	logic [SAMPLE_W-1:0] in_qsize;
	logic [15:0]         in_clients;
	logic [2:0]          in_factor;
	logic [7:0]          win_a;
	logic [7:0]          win_b;
	logic [AW-1:0]       len_a;
	logic [AW-1:0]       len_b;
	logic [2:0]          k_hi;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [SAMPLE_W-1:0] rd_data;
	walk_res_t           walk_res;
	status_t             next_status;
	logic                next_block;
	logic                ev_stop;
	logic                ev_shut;
	logic                ev_term;
	logic                out_free;

	assign in_qsize   = s_tdata[23:0];
	assign in_clients = s_tdata[39:24];
	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;

	// Client factor, clamp(1 + clients / 100, 1, 5), by comparison.
	always_comb begin
		if (in_clients >= 16'd400) begin
			in_factor = 3'd5;
		end else if (in_clients >= 16'd300) begin
			in_factor = 3'd4;
		end else if (in_clients >= 16'd200) begin
			in_factor = 3'd3;
		end else if (in_clients >= 16'd100) begin
			in_factor = 3'd2;
		end else begin
			in_factor = 3'd1;
		end
	end

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_unit_q    <= 20'd100000;
			suspend_win_q   <= 8'd5;
			resume_win_q    <= 8'd5;
			stop_win_q      <= 8'd30;
			shutdown_win_q  <= 8'd60;
			terminate_win_q <= 8'd90;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LEVEL_UNIT:       level_unit_q    <= cfg_data;
				REG_SUSPEND_WINDOW:   suspend_win_q   <= cfg_data[7:0];
				REG_RESUME_WINDOW:    resume_win_q    <= cfg_data[7:0];
				REG_STOP_WINDOW:      stop_win_q      <= cfg_data[7:0];
				REG_SHUTDOWN_WINDOW:  shutdown_win_q  <= cfg_data[7:0];
				REG_TERMINATE_WINDOW: terminate_win_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Window selection by status: window a is tested in every state but terminate,
	// window b (stop) only in suspend.
	always_comb begin
		win_b = 8'd1;
		k_hi  = 3'd2;
		case (status_q)
			ST_OK: begin
				win_a = suspend_win_q;
			end
			ST_SUSPEND: begin
				win_a = resume_win_q;
				win_b = stop_win_q;
				k_hi  = 3'd3;
			end
			ST_STOP_NET: begin
				win_a = shutdown_win_q;
				k_hi  = 3'd4;
			end
			ST_SHUTDOWN: begin
				win_a = terminate_win_q;
				k_hi  = 3'd5;
			end
			default: begin
				win_a = 8'd1;
			end
		endcase
	end

	// Number of older samples to read: clamp(window, 1, fill) minus the current one.
	function automatic logic [AW-1:0] older_len(input logic [7:0] win,
			input logic [CW-1:0] fill);
		logic [NW-1:0] w;
		logic [NW-1:0] f;
		logic [NW-1:0] n;
		w = (win == 8'd0) ? NW'(1) : NW'(win);
		f = NW'(fill);
		n = (w > f) ? f : w;
		return AW'(n - 1'b1);
	endfunction

	assign len_a = older_len(win_a, fill_q);
	assign len_b = (status_q == ST_SUSPEND) ? older_len(win_b, fill_q) : '0;

	// Sequencer and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wp_q     <= '0;
			fill_q   <= '0;
			status_q <= ST_OK;
			block_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						wp_q <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						if (fill_q < CW'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (walk_res.done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						status_q <= next_status;
						block_q  <= next_block;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Sample capture, base step and thresholds.
	always_ff @(posedge clk) begin
		if (accept) begin
			qsize_q    <= in_qsize;
			factor_q   <= in_factor;
			cur_addr_q <= wp_q;
		end
		if (state_q == S_PREP) begin
			step_q <= STEP_W'(level_unit_q) * STEP_W'(factor_q);
		end
		if (state_q == S_WALK) begin
			thr_lo_q <= THR_W'(step_q);
			thr_hi_q <= THR_W'(step_q) * THR_W'(k_hi);
		end
	end

	// Escalation decision from the window minima; stop wins over resume.
	always_comb begin
		next_status = status_q;
		ev_stop     = 1'b0;
		ev_shut     = 1'b0;
		ev_term     = 1'b0;
		case (status_q)
			ST_OK: begin
				if (THR_W'(walk_res.min_a) > thr_hi_q) begin
					next_status = ST_SUSPEND;
				end
			end
			ST_SUSPEND: begin
				if (THR_W'(walk_res.min_a) < thr_lo_q) begin
					next_status = ST_OK;
				end
				if (THR_W'(walk_res.min_b) > thr_hi_q) begin
					next_status = ST_STOP_NET;
					ev_stop     = 1'b1;
				end
			end
			ST_STOP_NET: begin
				if (THR_W'(walk_res.min_a) > thr_hi_q) begin
					next_status = ST_SHUTDOWN;
					ev_shut     = 1'b1;
				end
			end
			ST_SHUTDOWN: begin
				if (THR_W'(walk_res.min_a) > thr_hi_q) begin
					next_status = ST_TERMINATE;
					ev_term     = 1'b1;
				end
			end
			default: begin
				next_status = status_q;
			end
		endcase
		if (next_status == ST_OK) begin
			next_block = 1'b0;
		end else if (next_status == ST_SUSPEND) begin
			next_block = 1'b1;
		end else begin
			next_block = block_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DECIDE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DECIDE) && out_free) begin
			out_data_q <= {1'b0, ev_term, ev_shut, ev_stop, next_block, next_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	qbew_hist_mem #(
		.DEPTH(HISTORY_DEPTH),
		.AW   (AW)
	) u_hist_mem (
		.clk  (clk),
		.we   (accept),
		.waddr(wp_q),
		.wdata(in_qsize),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	qbew_walker #(
		.DEPTH(HISTORY_DEPTH),
		.AW   (AW)
	) u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_PREP),
		.cur_addr(cur_addr_q),
		.len_a   (len_a),
		.len_b   (len_b),
		.seed    (qsize_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (walk_res)
	);

	// Terminate is final.
	`QBEW_ASSERT(a_terminate_holds, status_q == ST_TERMINATE |=> $stable(status_q), "terminate left")
	// No sample is taken while the history walk is running.
	`QBEW_NEVER(a_ready_while_walking, s_tready && walk_res.busy, "ready during walk")
	// Suspend always carries the sync-block flag.
	`QBEW_ASSERT(a_suspend_blocks, status_q == ST_SUSPEND |-> block_q, "suspend without block flag")
	// A stop event is only reported together with the stop status.
	`QBEW_ASSERT(a_stop_event_status, m_tvalid && m_tdata[4] |-> m_tdata[2:0] == ST_STOP_NET, "stop event")

endmodule

@@ verif/qbew_checker.sv @@
// Checker for the queue backlog escalation watchdog: predicts every result beat and compares it.
`timescale 1ns / 1ps
module qbew_checker
	import qbew_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [19:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// tdata: queue_size [23:0], client_count [39:24].
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// tdata: status [2:0], sync_blocked [3], stop_net_event [4], shutdown_event [5],
	// terminate_event [6], zero [7].
	input  logic [7:0]  m_tdata,
	output int          mismatches,
	output int          outstanding
);

	localparam int DEPTH = 128;
	localparam int REPORT_LIMIT = 10;
	localparam int CLIENTS_PER_STEP = 100;
	localparam int MAX_SCALE = 5;

	// One predicted result beat.
	typedef struct {
		status_t status;
		logic    blocked;
		logic    stop_ev;
		logic    shut_ev;
		logic    term_ev;
	} outcome_t;

	outcome_t            expected_q[$];
	logic [SAMPLE_W-1:0] ring [DEPTH];
	int                  wr_ptr;
	int                  filled;
	status_t             level;
	logic                blocked;
	logic [19:0]         unit;
	logic [7:0]          win_suspend;
	logic [7:0]          win_resume;
	logic [7:0]          win_stop;
	logic [7:0]          win_shutdown;
	logic [7:0]          win_terminate;
	int                  errs;
	int                  beats;

	// Smallest of the newest samples in a window; a zero window means the newest only,
	// and the walk never reaches past what has been stored.
	function automatic logic [SAMPLE_W-1:0] history_min(input logic [7:0] win);
		int                  n;
		int                  idx;
		logic [SAMPLE_W-1:0] lowest;
		n = (win == 0) ? 1 : int'(win);
		if (n > filled) n = filled;
		idx = wr_ptr;
		lowest = '1;
		for (int i = 0; i < n; i++) begin
			idx = (idx == 0) ? DEPTH - 1 : idx - 1;
			if (ring[idx] < lowest) lowest = ring[idx];
		end
		return lowest;
	endfunction

	// Stores one sample and moves the escalation state, returning the result it causes.
	function automatic outcome_t advance_watchdog(input logic [23:0] qs, input logic [15:0] cl);
		outcome_t          o;
		int unsigned       scale;
		longint unsigned   step;
		scale = 1 + cl / CLIENTS_PER_STEP;
		if (scale > MAX_SCALE) scale = MAX_SCALE;
		step = longint'(unit) * scale;
		o.stop_ev = 1'b0;
		o.shut_ev = 1'b0;
		o.term_ev = 1'b0;

		ring[wr_ptr] = qs;
		wr_ptr = (wr_ptr + 1) % DEPTH;
		if (filled < DEPTH) filled++;

		case (level)
			ST_OK: begin
				if (history_min(win_suspend) > 2 * step) level = ST_SUSPEND;
			end
			ST_SUSPEND: begin
				// Resume is tested first, so a stop on the same sample wins.
				if (history_min(win_resume) < step) level = ST_OK;
				if (history_min(win_stop) > 3 * step) begin
					level = ST_STOP_NET;
					o.stop_ev = 1'b1;
				end
			end
			ST_STOP_NET: begin
				if (history_min(win_shutdown) > 4 * step) begin
					level = ST_SHUTDOWN;
					o.shut_ev = 1'b1;
				end
			end
			ST_SHUTDOWN: begin
				if (history_min(win_terminate) > 5 * step) begin
					level = ST_TERMINATE;
					o.term_ev = 1'b1;
				end
			end
			default: begin
				// Terminate holds.
			end
		endcase

		// The flag follows ok and suspend and holds in the escalated states.
		if (level == ST_OK) blocked = 1'b0;
		else if (level == ST_SUSPEND) blocked = 1'b1;
		o.status = level;
		o.blocked = blocked;
		return o;
	endfunction

	// Snoop register writes, compare result beats, then predict accepted sample beats.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		logic     bad;
		if (!arst_n) begin
			unit = 20'd100000;
			win_suspend = 8'd5;
			win_resume = 8'd5;
			win_stop = 8'd30;
			win_shutdown = 8'd60;
			win_terminate = 8'd90;
			wr_ptr = 0;
			filled = 0;
			level = ST_OK;
			blocked = 1'b0;
			expected_q.delete();
			errs = 0;
			beats = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_LEVEL_UNIT:       unit = cfg_data;
					REG_SUSPEND_WINDOW:   win_suspend = cfg_data[7:0];
					REG_RESUME_WINDOW:    win_resume = cfg_data[7:0];
					REG_STOP_WINDOW:      win_stop = cfg_data[7:0];
					REG_SHUTDOWN_WINDOW:  win_shutdown = cfg_data[7:0];
					REG_TERMINATE_WINDOW: win_terminate = cfg_data[7:0];
					default: begin
						// Writes past the register list are dropped.
					end
				endcase
			end

			if (m_tvalid && m_tready) begin
				beats++;
				if (expected_q.size() == 0) begin
					errs++;
					if (errs <= REPORT_LIMIT)
						$display("result beat %0d arrived with nothing expected: m_tdata %h",
							beats, m_tdata);
				end else begin
					want = expected_q.pop_front();
					bad = (m_tdata[2:0] != want.status) || (m_tdata[3] != want.blocked) ||
						(m_tdata[4] != want.stop_ev) || (m_tdata[5] != want.shut_ev) ||
						(m_tdata[6] != want.term_ev) || (m_tdata[7] != 1'b0);
					if (bad) begin
						errs++;
						if (errs <= REPORT_LIMIT)
							$display("result beat %0d: expected status %0d blocked %b events %b%b%b, got m_tdata %h",
								beats, want.status, want.blocked, want.stop_ev, want.shut_ev,
								want.term_ev, m_tdata);
					end
				end
			end

			if (s_tvalid && s_tready)
				expected_q.push_back(advance_watchdog(s_tdata[23:0], s_tdata[39:24]));

			mismatches <= errs;
			outstanding <= expected_q.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// Testbench top for the queue backlog escalation watchdog: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import qbew_pkg::*;

	// Writes to these indexes lie past the register list and must change nothing.
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	// Sample counts at which the idling pattern changes.
	localparam int SWAP_AT = 460;
	localparam int CALM_AT = 920;
	localparam int RANDOM_ITEMS = 290;
	localparam int MAX_QS = 24'hFFFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [19:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	int          mismatches;
	int          outstanding;

	int          tx_idle_pct = 34;
	int          rx_idle_pct = 72;
	int          sent = 0;
	int unsigned unit_now = 100000;
	int          susp_span = 5;

	queue_backlog_escalation_watchdog u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	qbew_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver stalls at random, at the rate of the current idling pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offers one sample beat after a random gap and returns at the edge that takes it.
	task automatic send_sample(input logic [23:0] qs, input logic [15:0] cl);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cl, qs};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (sent == SWAP_AT) begin
			tx_idle_pct = 72;
			rx_idle_pct = 34;
		end else if (sent == CALM_AT) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	// Stops offering samples and waits until every predicted result beat has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// One register write per clock; the caller lowers the write enable afterwards.
	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Loads a full setting; window writes carry random upper bits that must be dropped.
	task automatic apply_setting(input int unsigned lu, input int sw, input int rw,
		input int tw, input int hw, input int xw);
		write_reg(REG_LEVEL_UNIT, lu[19:0]);
		write_reg(REG_SUSPEND_WINDOW, {12'($urandom), sw[7:0]});
		write_reg(REG_RESUME_WINDOW, {12'($urandom), rw[7:0]});
		write_reg(REG_STOP_WINDOW, {12'($urandom), tw[7:0]});
		write_reg(REG_SHUTDOWN_WINDOW, {12'($urandom), hw[7:0]});
		write_reg(REG_TERMINATE_WINDOW, {12'($urandom), xw[7:0]});
		write_reg(REG_SPARE_A, 20'($urandom));
		write_reg(REG_SPARE_B, 20'($urandom));
		cfg_we <= 1'b0;
		unit_now = lu;
		susp_span = (sw[7:0] == 0) ? 1 : ((sw[7:0] > 128) ? 128 : int'(sw[7:0]));
	endtask

	// Random traffic that swings between ok and suspend without ever stopping: every
	// sample stays at or under level three except lone spikes that follow one that does,
	// so each stop window of two or more holds a sample at or under level three.
	task automatic run_bursts(input int n_items);
		int          done;
		int          f;
		int          run;
		logic [15:0] cl;
		logic [23:0] qs;
		bit          spiked;
		done = 0;
		while (done < n_items) begin
			f = $urandom_range(1, 5);
			if ($urandom_range(0, 9) < 7) begin
				// Climb above level two for a stretch around the suspend window.
				run = $urandom_range(1, susp_span + 8);
				spiked = 1'b0;
				for (int k = 0; k < run; k++) begin
					cl = (f == 5) ? 16'($urandom_range(400, 65535)) :
						16'($urandom_range(100 * (f - 1), 100 * f - 1));
					if (k > 0 && !spiked && $urandom_range(0, 9) == 0) begin
						qs = 24'($urandom_range(3 * unit_now * f + 1, MAX_QS));
						spiked = 1'b1;
					end else begin
						qs = 24'($urandom_range(2 * unit_now * f + 1, 3 * unit_now * f));
						spiked = 1'b0;
					end
					send_sample(qs, cl);
				end
				done += run;
				// Drop below level one at any client count so suspend resumes.
				run = $urandom_range(1, 4);
				repeat (run) send_sample(24'($urandom_range(0, unit_now - 1)), 16'($urandom));
				done += run;
			end else begin
				// Noise up to level three at each sample's own client factor.
				run = $urandom_range(1, 6);
				repeat (run) begin
					cl = 16'($urandom);
					f = (cl >= 400) ? 5 : cl / 100 + 1;
					send_sample(24'($urandom_range(0, 3 * unit_now * f)), cl);
				end
				done += run;
			end
		end
	endtask

	// Main sequence.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: short history, field extremes, ties at level two, suspend and resume.
		send_sample(24'd0, 16'd0);
		send_sample(24'hFFFFFF, 16'hFFFF);
		repeat (5) send_sample(24'd200000, 16'd0);
		send_sample(24'hFFFFFF, 16'd99);
		send_sample(24'd300000, 16'd100);
		repeat (5) send_sample(24'd200001, 16'd0);
		send_sample(24'd100000, 16'd0);
		send_sample(24'd99999, 16'd0);
		send_sample(24'hFFFFFF, 16'd65535);
		send_sample(24'd50000, 16'd399);
		send_sample(24'd50000, 16'd400);
		run_bursts(RANDOM_ITEMS);

		// Largest level unit, single-sample suspend and windows at and past the ring depth.
		drain();
		apply_setting(1048575, 1, 128, 128, 7, 200);
		run_bursts(RANDOM_ITEMS);

		// Smallest level unit, full-depth suspend window, zero resume window.
		drain();
		apply_setting(1, 128, 0, 2, 255, 0);
		run_bursts(RANDOM_ITEMS);

		// Random setting.
		drain();
		apply_setting($urandom_range(1000, 1048575), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(2, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		run_bursts(RANDOM_ITEMS);

		// Escalation: resume and stop on the same sample, a tie at level four, then shutdown.
		drain();
		apply_setting(100000, 1, 2, 1, 0, 255);
		send_sample(24'd50000, 16'd0);
		send_sample(24'd250000, 16'd0);
		send_sample(24'd250000, 16'd0);
		send_sample(24'd1600000, 16'd65535);
		send_sample(24'd400000, 16'd0);
		send_sample(24'hFFFFFF, 16'd0);
		send_sample(24'd500000, 16'd0);

		// A zero level unit lets a full window of nonzero samples terminate; terminate holds.
		drain();
		write_reg(REG_LEVEL_UNIT, 20'd0);
		cfg_we <= 1'b0;
		unit_now = 0;
		repeat (140) send_sample(24'($urandom_range(1, MAX_QS)), 16'($urandom));
		repeat (50) send_sample(24'($urandom_range(0, MAX_QS)), 16'($urandom));

		drain();
		repeat (140) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog on the whole run.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/qbew_pkg.sv
src/qbew_hist_mem.sv
src/qbew_walker.sv
src/queue_backlog_escalation_watchdog.sv
verif/qbew_checker.sv
verif/testbench.sv
